// ----- design/cbc_pkg.sv -----
`default_nettype none
package cbc_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned COUNT_W = 21;
  localparam int unsigned SUM_W   = 30;
  localparam int unsigned CTR_W   = 10;
  localparam int unsigned CFG_W   = 21;
  localparam int unsigned IDX_W   = 3;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  // effective frame size, wide enough for the largest allowed maximum
  localparam int unsigned WEFF_W = 13;

  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [IDX_W-1:0] CFG_TARGET_U     = 3'd0;
  localparam logic [IDX_W-1:0] CFG_TARGET_V     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_THRESHOLD    = 3'd2;
  localparam logic [IDX_W-1:0] CFG_MIN_PIXELS   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd4;
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;

  localparam logic [CHAN_W-1:0]  RST_TARGET_U   = 8'd101;
  localparam logic [CHAN_W-1:0]  RST_TARGET_V   = 8'd188;
  localparam logic [CHAN_W-1:0]  RST_THRESHOLD  = 8'd16;
  localparam logic [COUNT_W-1:0] RST_MIN_PIXELS = 21'd0;
  localparam logic [SIZE_W-1:0]  RST_WIDTH      = 11'd640;
  localparam logic [SIZE_W-1:0]  RST_HEIGHT     = 11'd480;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic               found;
    logic [CTR_W-1:0]   centre_x;
    logic [CTR_W-1:0]   centre_y;
    logic [COUNT_W-1:0] match_count;
  } result_t;

  typedef struct packed {
    logic accept;
    logic load_div;
    logic div_step;
    logic load_out;
  } cbc_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic div_done;
    logic out_busy;
  } cbc_status_t;

  typedef enum logic {
    ST_RUN,
    ST_DIV
  } cbc_state_e;

  function automatic logic [WEFF_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
                                                   logic [WEFF_W-1:0] hi);
    logic [WEFF_W-1:0] ve;
    ve = WEFF_W'(v);
    if (ve < WEFF_W'(3)) return WEFF_W'(3);
    if (ve > hi) return hi;
    return ve;
  endfunction

  // ((s + 127) >> 8) + 128 folded into one offset; the sum stays positive
  function automatic logic [CHAN_W-1:0] chroma_u(logic [CHAN_W-1:0] r,
                                                 logic [CHAN_W-1:0] g,
                                                 logic [CHAN_W-1:0] b);
    logic signed [17:0] s;
    s = 18'sd32895 - 18'sd38 * signed'({10'd0, r}) - 18'sd74 * signed'({10'd0, g})
        + 18'sd112 * signed'({10'd0, b});
    return s[15:8];
  endfunction

  function automatic logic [CHAN_W-1:0] chroma_v(logic [CHAN_W-1:0] r,
                                                 logic [CHAN_W-1:0] g,
                                                 logic [CHAN_W-1:0] b);
    logic signed [17:0] s;
    s = 18'sd32895 + 18'sd112 * signed'({10'd0, r}) - 18'sd94 * signed'({10'd0, g})
        - 18'sd18 * signed'({10'd0, b});
    return s[15:8];
  endfunction

  function automatic logic in_window(logic [CHAN_W-1:0] val,
                                     logic [CHAN_W-1:0] target,
                                     logic [CHAN_W-1:0] thr);
    logic [CHAN_W:0] lo;
    logic [CHAN_W:0] hi;
    lo = (target >= thr) ? {1'b0, target - thr} : '0;
    hi = {1'b0, target} + {1'b0, thr};
    return ({1'b0, val} >= lo) && ({1'b0, val} <= hi);
  endfunction

endpackage
`default_nettype wire

// ----- design/cbc_ctrl.sv -----
`default_nettype none
module cbc_ctrl
  import cbc_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  cbc_status_t status_i,
  output cbc_cmd_t    cmd_o
);

  cbc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_RUN: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && status_i.frame_end) begin
          cmd_o.load_div = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!status_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else if (!status_i.out_busy) begin
          // previous result gone or being taken, hand the new one over
          cmd_o.load_out = 1'b1;
          state_d        = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- design/cbc_datapath.sv -----
`default_nettype none
module cbc_datapath
  import cbc_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  input  pixel_t             pixel_i,
  input  cbc_cmd_t           cmd_i,
  output cbc_status_t        status_o,
  input  wire                cfg_write_i,
  input  wire  [IDX_W-1:0]   cfg_index_i,
  input  wire  [CFG_W-1:0]   cfg_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output result_t            out_data_o
);

  logic [CHAN_W-1:0]  target_u_q, target_v_q, thr_q;
  logic [COUNT_W-1:0] min_pixels_q;
  logic [SIZE_W-1:0]  width_q, height_q;

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [SUM_W-1:0]   col_sum_q, col_sum_d;
  logic [SUM_W-1:0]   row_sum_q, row_sum_d;

  logic [COUNT_W-1:0] den_q;
  logic [SUM_W-1:0]   qx_q, qy_q;
  logic [COUNT_W-1:0] rx_q, ry_q;
  logic [STEP_W-1:0]  step_q;
  logic               found_q;

  logic               out_valid_q;
  result_t            out_q;

  logic [WEFF_W-1:0]  w_eff, h_eff;
  logic               last_col, last_row, interior, hit;
  logic [CHAN_W-1:0]  u_val, v_val;
  logic [SUM_W:0]     col_add, row_add;
  logic [COUNT_W:0]   rx_sh, ry_sh;
  logic               gex, gey;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_u_q   <= RST_TARGET_U;
      target_v_q   <= RST_TARGET_V;
      thr_q        <= RST_THRESHOLD;
      min_pixels_q <= RST_MIN_PIXELS;
      width_q      <= RST_WIDTH;
      height_q     <= RST_HEIGHT;
    end else if (cfg_write_i) begin
      case (cfg_index_i)
        CFG_TARGET_U:     target_u_q   <= cfg_data_i[CHAN_W-1:0];
        CFG_TARGET_V:     target_v_q   <= cfg_data_i[CHAN_W-1:0];
        CFG_THRESHOLD:    thr_q        <= cfg_data_i[CHAN_W-1:0];
        CFG_MIN_PIXELS:   min_pixels_q <= cfg_data_i[COUNT_W-1:0];
        CFG_FRAME_WIDTH:  width_q      <= cfg_data_i[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: height_q     <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_size(width_q, WEFF_W'(MAX_WIDTH));
  assign h_eff = clamp_size(height_q, WEFF_W'(MAX_HEIGHT));

  assign last_col = WEFF_W'(col_q) >= (w_eff - WEFF_W'(1));
  assign last_row = WEFF_W'(row_q) >= (h_eff - WEFF_W'(1));
  assign interior = (col_q != '0) && !last_col && (row_q != '0) && !last_row;

  assign u_val = chroma_u(pixel_i.red, pixel_i.green, pixel_i.blue);
  assign v_val = chroma_v(pixel_i.red, pixel_i.green, pixel_i.blue);
  assign hit   = interior && in_window(u_val, target_u_q, thr_q)
                 && in_window(v_val, target_v_q, thr_q);

  assign col_add = {1'b0, col_sum_q} + (SUM_W + 1)'(col_q);
  assign row_add = {1'b0, row_sum_q} + (SUM_W + 1)'(row_q);

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    count_d   = count_q;
    col_sum_d = col_sum_q;
    row_sum_d = row_sum_q;
    if (cmd_i.accept) begin
      if (hit) begin
        count_d   = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + COUNT_W'(1);
        col_sum_d = col_add[SUM_W] ? SUM_MAX : col_add[SUM_W-1:0];
        row_sum_d = row_add[SUM_W] ? SUM_MAX : row_add[SUM_W-1:0];
      end
      if (!last_col) begin
        col_d = col_q + COL_W'(1);
      end else begin
        col_d = '0;
        if (!last_row) begin
          row_d = row_q + ROW_W'(1);
        end else begin
          row_d     = '0;
          count_d   = '0;
          col_sum_d = '0;
          row_sum_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      count_q   <= '0;
      col_sum_q <= '0;
      row_sum_q <= '0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      count_q   <= count_d;
      col_sum_q <= col_sum_d;
      row_sum_q <= row_sum_d;
    end
  end

  // two restoring dividers sharing the count as divisor, one quotient bit a cycle
  assign rx_sh = {rx_q, qx_q[SUM_W-1]};
  assign ry_sh = {ry_q, qy_q[SUM_W-1]};
  assign gex   = rx_sh >= {1'b0, den_q};
  assign gey   = ry_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load_div) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div) begin
      den_q   <= count_q;
      found_q <= count_q > min_pixels_q;
      qx_q    <= col_sum_q;
      qy_q    <= row_sum_q;
      rx_q    <= '0;
      ry_q    <= '0;
    end else if (cmd_i.div_step) begin
      qx_q <= {qx_q[SUM_W-2:0], gex};
      qy_q <= {qy_q[SUM_W-2:0], gey};
      rx_q <= gex ? COUNT_W'(rx_sh - {1'b0, den_q}) : rx_sh[COUNT_W-1:0];
      ry_q <= gey ? COUNT_W'(ry_sh - {1'b0, den_q}) : ry_sh[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.found       <= found_q;
      out_q.centre_x    <= (den_q == '0) ? '0 : qx_q[CTR_W-1:0];
      out_q.centre_y    <= (den_q == '0) ? '0 : qy_q[CTR_W-1:0];
      out_q.match_count <= den_q;
    end
  end

  assign status_o.frame_end = last_col && last_row;
  assign status_o.div_done  = step_q == STEP_W'(DIV_STEPS);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ----- design/color_blob_centroid_core.sv -----
`default_nettype none
// channel   direction  handshake               payload
// pixel     in         in_valid_i / in_ready_o    in_data_i (pixel_t)
// result    out        out_valid_o / out_ready_i  out_data_o (result_t)
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one pixel per cycle within a frame; the chroma test and accumulation sit in one cycle
// the last pixel of a frame starts a bit-serial divide of the sums by the count,
// pixel input is held off during the divide and while the result register is loaded;
// the divide end also waits while a previous result is still untaken
// reset restores the register defaults and clears position and accumulators at once
// config writes are always taken, one per cycle
module color_blob_centroid_core
  import cbc_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  pixel_t            in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output result_t           out_data_o,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire [IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_W-1:0]   cfg_data_i
);

  cbc_cmd_t    cmd;
  cbc_status_t status;

  assign cfg_ready_o = 1'b1;

  cbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cbc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_load_out_after_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> status.div_done)
    else $error("result loaded before divide finished");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && !out_ready_i))
    else $error("pending result overwritten");

  a_div_from_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_div |-> (in_valid_i && in_ready_o && status.frame_end))
    else $error("divide started without frame end transaction");

  a_stall_after_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_div |=> !in_ready_o)
    else $error("pixel input open during divide");

endmodule
`default_nettype wire
